>>> design/interval_timer_counter0_macros.svh
// ----------------------------------------------------------------------------
// interval_timer_counter0 assertion macros
// shared concurrent assertion shorthands, clocked on clock, off in reset
// ----------------------------------------------------------------------------
`ifndef INTERVAL_TIMER_COUNTER0_MACROS_SVH
`define INTERVAL_TIMER_COUNTER0_MACROS_SVH

// same-cycle implication
`define ITC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("interval timer check failed");

// next-cycle implication
`define ITC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("interval timer check failed");

`endif

>>> design/itc_pkg.sv
// ----------------------------------------------------------------------------
// itc_pkg
// types and constants shared by the interval timer counter 0 files
// ----------------------------------------------------------------------------
`default_nettype none

package itc_pkg;

   localparam int COUNT_BITS_DEF = 16;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_CTRL  = 2'd1,
      KIND_WDATA = 2'd2,
      KIND_RDATA = 2'd3
   } kind_type;

   // control byte field codes
   localparam logic [1:0] SEL_COUNTER0 = 2'd0;
   localparam logic [1:0] ACC_LATCH    = 2'd0;
   localparam logic [1:0] ACC_LOHI     = 2'd3;
   localparam logic [2:0] MODE_RATE    = 3'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       out_level;
      logic       out_rise;
   } rsp_word_type;

endpackage

`default_nettype wire

>>> design/itc_if.sv
// ----------------------------------------------------------------------------
// itc_req_if / itc_rsp_if
// valid/ready channels for request and response words
// ----------------------------------------------------------------------------
`default_nettype none

interface itc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface itc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       out_level;
   logic       out_rise;

   modport source (output valid, output read_data, output out_level, output out_rise,
                   input ready);
   modport sink   (input valid, input read_data, input out_level, input out_rise,
                   output ready);
endinterface

`default_nettype wire

>>> design/itc_core.sv
// ----------------------------------------------------------------------------
// itc_core
// counter 0 state and the state update for one request word
// ----------------------------------------------------------------------------
`default_nettype none

module itc_core #(
   parameter int COUNT_BITS = itc_pkg::COUNT_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 go,
   input  wire itc_pkg::req_word_type item,
   output itc_pkg::rsp_word_type      result
);
   import itc_pkg::*;
`include "interval_timer_counter0_macros.svh"

   logic [COUNT_BITS-1:0] count_now_ff, count_now_in;
   logic [COUNT_BITS-1:0] reload_value_ff, reload_value_in;
   logic [7:0]            low_byte_hold_ff, low_byte_hold_in;
   logic                  rate_mode_ff, rate_mode_in;
   logic                  write_high_next_ff, write_high_next_in;
   logic                  read_high_next_ff, read_high_next_in;
   logic [COUNT_BITS-1:0] latch_copy_ff, latch_copy_in;
   logic                  latch_held_ff, latch_held_in;
   logic                  armed_ff, armed_in;
   logic                  line_level_ff, line_level_in;

   logic [1:0]            ctl_sel, ctl_acc;
   logic [2:0]            ctl_mode;
   logic [15:0]           loaded_word;
   logic [COUNT_BITS-1:0] count_dec, read_src;
   logic [31:0]           read_wide;
   logic [7:0]            rd_byte;

   assign ctl_sel     = item.data_byte[7:6];
   assign ctl_acc     = item.data_byte[5:4];
   assign ctl_mode    = item.data_byte[3:1];
   assign loaded_word = {item.data_byte, low_byte_hold_ff};
   assign count_dec   = count_now_ff - COUNT_BITS'(1);
   assign read_src    = latch_held_ff ? latch_copy_ff : count_now_ff;
   assign read_wide   = 32'(read_src);

   always_comb begin
      count_now_in       = count_now_ff;
      reload_value_in    = reload_value_ff;
      low_byte_hold_in   = low_byte_hold_ff;
      rate_mode_in       = rate_mode_ff;
      write_high_next_in = write_high_next_ff;
      read_high_next_in  = read_high_next_ff;
      latch_copy_in      = latch_copy_ff;
      latch_held_in      = latch_held_ff;
      armed_in           = armed_ff;
      line_level_in      = line_level_ff;
      rd_byte            = 8'd0;
      case (kind_type'(item.kind))
         KIND_TICK: begin
            if (armed_ff) begin
               if (rate_mode_ff) begin
                  if (count_now_ff == COUNT_BITS'(1)) begin
                     count_now_in  = reload_value_ff;
                     line_level_in = 1'b1;
                  end else begin
                     count_now_in = count_dec;
                     if (count_dec == COUNT_BITS'(1)) line_level_in = 1'b0;
                  end
               end else begin
                  count_now_in = count_dec;
                  if (count_dec == '0) line_level_in = 1'b1;
               end
            end
         end
         KIND_CTRL: begin
            if (ctl_sel == SEL_COUNTER0) begin
               if (ctl_acc == ACC_LATCH) begin
                  if (!latch_held_ff) begin
                     latch_copy_in = count_now_ff;
                     latch_held_in = 1'b1;
                  end
               end else if (ctl_acc == ACC_LOHI) begin
                  rate_mode_in       = (ctl_mode == MODE_RATE);
                  write_high_next_in = 1'b0;
                  read_high_next_in  = 1'b0;
                  latch_held_in      = 1'b0;
                  armed_in           = 1'b0;
                  line_level_in      = (ctl_mode == MODE_RATE);
               end
            end
         end
         KIND_WDATA: begin
            if (!write_high_next_ff) begin
               low_byte_hold_in   = item.data_byte;
               write_high_next_in = 1'b1;
               if (!rate_mode_ff) begin
                  armed_in      = 1'b0;
                  line_level_in = 1'b0;
               end
            end else begin
               reload_value_in    = COUNT_BITS'(loaded_word);
               count_now_in       = COUNT_BITS'(loaded_word);
               write_high_next_in = 1'b0;
               armed_in           = 1'b1;
               if (!rate_mode_ff) line_level_in = 1'b0;
            end
         end
         KIND_RDATA: begin
            if (!read_high_next_ff) begin
               read_high_next_in = 1'b1;
               rd_byte           = read_wide[7:0];
            end else begin
               read_high_next_in = 1'b0;
               latch_held_in     = 1'b0;
               rd_byte           = read_wide[15:8];
            end
         end
         default: begin
            rd_byte = 8'd0;
         end
      endcase
   end

   assign result.read_data = rd_byte;
   assign result.out_level = line_level_in;
   assign result.out_rise  = line_level_in & ~line_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_now_ff       <= '0;
         reload_value_ff    <= '0;
         low_byte_hold_ff   <= '0;
         rate_mode_ff       <= 1'b0;
         write_high_next_ff <= 1'b0;
         read_high_next_ff  <= 1'b0;
         latch_copy_ff      <= '0;
         latch_held_ff      <= 1'b0;
         armed_ff           <= 1'b0;
         line_level_ff      <= 1'b1;
      end else if (go) begin
         count_now_ff       <= count_now_in;
         reload_value_ff    <= reload_value_in;
         low_byte_hold_ff   <= low_byte_hold_in;
         rate_mode_ff       <= rate_mode_in;
         write_high_next_ff <= write_high_next_in;
         read_high_next_ff  <= read_high_next_in;
         latch_copy_ff      <= latch_copy_in;
         latch_held_ff      <= latch_held_in;
         armed_ff           <= armed_in;
         line_level_ff      <= line_level_in;
      end
   end

   // reads never move the output line
   `ITC_ASSERT_NOW(a_read_no_rise, go && (item.kind == KIND_RDATA), !result.out_rise)
   // an idle counter ignores ticks
   `ITC_ASSERT_NEXT(a_unarmed_hold, go && (item.kind == KIND_TICK) && !armed_ff,
                    $stable(count_now_ff))
   // one-shot terminal count drives the line high
   `ITC_ASSERT_NEXT(a_oneshot_tc,
                    go && (item.kind == KIND_TICK) && armed_ff && !rate_mode_ff &&
                    (count_now_ff == COUNT_BITS'(1)), line_level_ff)

endmodule

`default_nettype wire

>>> design/interval_timer_counter0.sv
// ----------------------------------------------------------------------------
// interval_timer_counter0
// counter 0 of an 8254-style interval timer behind valid/ready channels
// ----------------------------------------------------------------------------
// Each request word is a tick, a control byte write, a data write or a data
// read, and each gives exactly one response word with the read byte, the
// output line level and a rising-edge flag for interrupt use. Throughput is
// one word per clock while responses are taken. An accepted request word
// sits in the input register while the counter core does the whole state
// update from it, and the response register captures the result when the
// word advances. A full response register that is not taken stalls the
// input register, which in turn drops req ready. COUNT_BITS sets the
// counter width.
`default_nettype none

module interval_timer_counter0 #(
   parameter int COUNT_BITS = itc_pkg::COUNT_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   itc_req_if.sink   req_chan,
   itc_rsp_if.source rsp_chan
);
   import itc_pkg::*;
`include "interval_timer_counter0_macros.svh"

   // input register
   logic         in_valid_ff, in_valid_in;
   req_word_type in_word_ff;
   // response register
   logic         out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff;
   rsp_word_type core_result;
   // the core consumes the held word when the response slot is free or draining
   logic         advance;
   logic         req_take;

   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || advance;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);

   itc_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .go     (advance),
      .item   (in_word_ff),
      .result (core_result)
   );

   // control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff.kind      <= req_chan.kind;
         in_word_ff.data_byte <= req_chan.data_byte;
      end
      if (advance) out_word_ff <= core_result;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.read_data = out_word_ff.read_data;
   assign rsp_chan.out_level = out_word_ff.out_level;
   assign rsp_chan.out_rise  = out_word_ff.out_rise;

   // a held word that cannot advance stays held
   `ITC_ASSERT_NEXT(a_in_kept, in_valid_ff && !advance, in_valid_ff)
   // a new response comes only from a core update
   `ITC_ASSERT_NOW(a_rsp_source, $rose(out_valid_ff), $past(advance))
   // a stalled response blocks the core
   `ITC_ASSERT_NOW(a_no_overrun, out_valid_ff && !rsp_chan.ready, !advance)

endmodule

`default_nettype wire
